[sv/irpd_pkg.sv]
// irpd_pkg: shared types, constants and the command to wheel speed map
// for the infrared remote pulse decoder; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package irpd_pkg;

  // field widths
  localparam int TICK_W   = 16;
  localparam int SPEED_W  = 7;
  localparam int WHEEL_W  = 8;
  localparam int FRAME_W  = 12;
  localparam int CMD_W    = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;

  // default code length, legal range 1 to 16
  localparam int CODE_BITS_DEF = 12;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_TICKS = 3'd0,
    REG_GUARD_TICKS = 3'd1,
    REG_BIT_TICKS   = 3'd2,
    REG_EXTRA_TICKS = 3'd3,
    REG_BASE_SPEED  = 3'd4
  } cfg_reg_t;

  // register reset values
  localparam logic [TICK_W-1:0]  START_TICKS_RST = 16'd210;
  localparam logic [TICK_W-1:0]  GUARD_TICKS_RST = 16'd60;
  localparam logic [TICK_W-1:0]  BIT_TICKS_RST   = 16'd120;
  localparam logic [TICK_W-1:0]  EXTRA_TICKS_RST = 16'd60;
  localparam logic [SPEED_W-1:0] BASE_SPEED_RST  = 7'd40;

  // mapped command codes
  localparam logic [CMD_W-1:0] CMD_FWD_LEFT  = 16'd2176;
  localparam logic [CMD_W-1:0] CMD_FWD       = 16'd2177;
  localparam logic [CMD_W-1:0] CMD_FWD_RIGHT = 16'd2178;
  localparam logic [CMD_W-1:0] CMD_SPIN_LEFT = 16'd2179;
  localparam logic [CMD_W-1:0] CMD_STOP      = 16'd2180;
  localparam logic [CMD_W-1:0] CMD_SPIN_RGHT = 16'd2181;
  localparam logic [CMD_W-1:0] CMD_REVERSE   = 16'd2183;

  // configuration bundle
  typedef struct packed {
    logic [TICK_W-1:0]  start_ticks;
    logic [TICK_W-1:0]  guard_ticks;
    logic [TICK_W-1:0]  bit_ticks;
    logic [TICK_W-1:0]  extra_ticks;
    logic [SPEED_W-1:0] base_speed;
  } cfg_t;

  // decoded wheel command
  typedef struct packed {
    logic               recognized;
    logic [WHEEL_W-1:0] left_speed;
    logic [WHEEL_W-1:0] right_speed;
  } wheel_t;

  // command code to wheel speeds
  function automatic wheel_t speed_map(input logic [CMD_W-1:0] code,
                                       input logic [SPEED_W-1:0] s);
    wheel_t             w;
    logic [WHEEL_W-1:0] pos;
    logic [WHEEL_W-1:0] neg;
    logic [WHEEL_W-1:0] half;
    pos  = {1'b0, s};
    neg  = ~pos + 8'd1;
    half = {2'b00, s[SPEED_W-1:1]};
    w.recognized  = 1'b1;
    w.left_speed  = '0;
    w.right_speed = '0;
    unique case (code)
      CMD_FWD_LEFT:  begin w.left_speed = half; w.right_speed = pos;  end
      CMD_FWD:       begin w.left_speed = pos;  w.right_speed = pos;  end
      CMD_FWD_RIGHT: begin w.left_speed = pos;  w.right_speed = half; end
      CMD_SPIN_LEFT: begin w.left_speed = neg;  w.right_speed = pos;  end
      CMD_SPIN_RGHT: begin w.left_speed = pos;  w.right_speed = neg;  end
      CMD_REVERSE:   begin w.left_speed = neg;  w.right_speed = neg;  end
      CMD_STOP:      begin w.left_speed = '0;   w.right_speed = '0;   end
      default:       w.recognized = 1'b0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[sv/irpd_cfg.sv]
// irpd_cfg: configuration register file of the pulse decoder
// depends on irpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module irpd_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [irpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [irpd_pkg::CFG_W-1:0]     cfg_wdata,
  output irpd_pkg::cfg_t                     cfg
);

  irpd_pkg::cfg_t cfg_r;
  irpd_pkg::cfg_t cfg_nxt;

  // register write decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        irpd_pkg::REG_START_TICKS: cfg_nxt.start_ticks = cfg_wdata;
        irpd_pkg::REG_GUARD_TICKS: cfg_nxt.guard_ticks = cfg_wdata;
        irpd_pkg::REG_BIT_TICKS:   cfg_nxt.bit_ticks   = cfg_wdata;
        irpd_pkg::REG_EXTRA_TICKS: cfg_nxt.extra_ticks = cfg_wdata;
        irpd_pkg::REG_BASE_SPEED:
          cfg_nxt.base_speed = cfg_wdata[irpd_pkg::SPEED_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_ticks <= irpd_pkg::START_TICKS_RST;
      cfg_r.guard_ticks <= irpd_pkg::GUARD_TICKS_RST;
      cfg_r.bit_ticks   <= irpd_pkg::BIT_TICKS_RST;
      cfg_r.extra_ticks <= irpd_pkg::EXTRA_TICKS_RST;
      cfg_r.base_speed  <= irpd_pkg::BASE_SPEED_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[sv/irpd_seq.sv]
// irpd_seq: pulse timing state machine, one pin sample per step
// depends on irpd_pkg
`timescale 1ns / 1ps
`default_nettype none

module irpd_seq #(
  parameter int CODE_BITS = irpd_pkg::CODE_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire logic                 pin,
  input  wire irpd_pkg::cfg_t       cfg,
  output logic                      res_valid,
  output logic [CODE_BITS-1:0]      res_code
);

  localparam int IDX_W = $clog2(CODE_BITS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CODE_BITS);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_START = 5'b00010,
    ST_GUARD = 5'b00100,
    ST_BIT   = 5'b01000,
    ST_EXTRA = 5'b10000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [irpd_pkg::TICK_W-1:0]  tick_r, tick_nxt;
  logic [IDX_W-1:0]             idx_r, idx_nxt;
  logic [CODE_BITS-1:0]         code_r, code_nxt;
  logic                         prev_r;

  logic [irpd_pkg::TICK_W-1:0]  tick_inc;
  logic [irpd_pkg::TICK_W-1:0]  st_len;
  logic [irpd_pkg::TICK_W-1:0]  bt_len;
  logic                         guard_zero;
  logic                         extra_zero;
  logic                         frame_done;

  // zero start and bit lengths act as one
  assign st_len     = (cfg.start_ticks == '0) ? 16'd1 : cfg.start_ticks;
  assign bt_len     = (cfg.bit_ticks == '0) ? 16'd1 : cfg.bit_ticks;
  assign guard_zero = (cfg.guard_ticks == '0);
  assign extra_zero = (cfg.extra_ticks == '0);
  assign tick_inc   = tick_r + 16'd1;
  assign frame_done = (idx_r == LAST_IDX);

  // next state for one sample
  always_comb begin
    state_nxt = state_r;
    tick_nxt  = tick_r;
    idx_nxt   = idx_r;
    code_nxt  = code_r;
    res_valid = 1'b0;
    unique case (state_r)
      ST_START: begin
        if (pin) begin
          state_nxt = ST_IDLE;
          tick_nxt  = '0;
        end else if (tick_inc >= st_len) begin
          tick_nxt  = '0;
          state_nxt = guard_zero ? ST_BIT : ST_GUARD;
        end else begin
          tick_nxt = tick_inc;
        end
      end
      ST_GUARD: begin
        if (tick_inc >= cfg.guard_ticks) begin
          state_nxt = ST_BIT;
          tick_nxt  = '0;
        end else begin
          tick_nxt = tick_inc;
        end
      end
      ST_BIT: begin
        if (tick_inc >= bt_len) begin
          // low sample is a one
          if (!pin) code_nxt = code_r | (CODE_BITS'(1) << idx_r);
          idx_nxt   = idx_r + IDX_W'(1);
          res_valid = step && (idx_nxt == LAST_IDX);
          tick_nxt  = '0;
          if (!pin && !extra_zero) state_nxt = ST_EXTRA;
          else if (idx_nxt == LAST_IDX) state_nxt = ST_IDLE;
          else state_nxt = ST_BIT;
        end else begin
          tick_nxt = tick_inc;
        end
      end
      ST_EXTRA: begin
        if (tick_inc >= cfg.extra_ticks) begin
          tick_nxt  = '0;
          state_nxt = frame_done ? ST_IDLE : ST_BIT;
        end else begin
          tick_nxt = tick_inc;
        end
      end
      default: begin
        // idle: falling edge opens the start check, or the guard or bit phase when the start length is one
        state_nxt = ST_IDLE;
        if (prev_r && !pin) begin
          code_nxt = '0;
          idx_nxt  = '0;
          if (st_len == 16'd1) begin
            tick_nxt  = '0;
            state_nxt = guard_zero ? ST_BIT : ST_GUARD;
          end else begin
            tick_nxt  = 16'd1;
            state_nxt = ST_START;
          end
        end
      end
    endcase
  end

  assign res_code = code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tick_r  <= '0;
      idx_r   <= '0;
      code_r  <= '0;
      prev_r  <= 1'b1;
    end else if (step) begin
      state_r <= state_nxt;
      tick_r  <= tick_nxt;
      idx_r   <= idx_nxt;
      code_r  <= code_nxt;
      prev_r  <= pin;
    end
  end

  // a result only comes out of a bit sample
  a_res_in_bit: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (state_r == ST_BIT) && step)
    else $error("result outside bit phase");

  // bit counter never passes the code length
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= LAST_IDX)
    else $error("bit index out of range");

  // the start check is left at once when the pin goes high
  a_start_abort: assert property (@(posedge clk) disable iff (!rst_n)
    step && (state_r == ST_START) && pin |=> state_r == ST_IDLE)
    else $error("start check not abandoned");

endmodule

`default_nettype wire

[sv/ir_remote_pulse_decoder_core.sv]
// ir_remote_pulse_decoder_core: top level of the infrared pulse decoder
// the result is written to the output register as the last-bit item leaves the input register
// throughput: one pin sample per cycle unless stalled, set by the single-step state machine
// a stalled result holds in the output register while one more item waits in the input register
// reset: synchronous active low; registers to defaults, idle, line taken as high
// depends on irpd_pkg, irpd_cfg, irpd_seq
`timescale 1ns / 1ps
`default_nettype none

module ir_remote_pulse_decoder_core #(
  parameter int CODE_BITS = irpd_pkg::CODE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [irpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [irpd_pkg::CFG_W-1:0]        cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_pin_level,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [irpd_pkg::FRAME_W-1:0]           out_frame_code,
  output logic                                   out_recognized,
  output logic signed [irpd_pkg::WHEEL_W-1:0]    out_left_speed,
  output logic signed [irpd_pkg::WHEEL_W-1:0]    out_right_speed
);

  irpd_pkg::cfg_t                   cfg;
  irpd_pkg::wheel_t                 wheel;
  logic                             in_valid_r;
  logic                             in_pin_r;
  logic                             step;
  logic                             out_open;
  logic                             res_valid;
  logic [CODE_BITS-1:0]             res_code;
  logic [irpd_pkg::CMD_W-1:0]       res_code_w;
  logic                             out_valid_r;
  logic [irpd_pkg::FRAME_W-1:0]     frame_r;
  irpd_pkg::wheel_t                 wheel_r;

  irpd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // handshake: step when the result slot is free or draining
  assign out_open = !out_valid_r || !out_stall;
  assign step     = in_valid_r && out_open;
  assign in_stall = in_valid_r && !step;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_pin_r <= in_pin_level;
    end
  end

  irpd_seq #(
    .CODE_BITS (CODE_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .pin       (in_pin_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_code  (res_code)
  );

  // full code compared, low bits shown
  assign res_code_w = irpd_pkg::CMD_W'(res_code);
  assign wheel      = irpd_pkg::speed_map(res_code_w, cfg.base_speed);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_open) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_open && res_valid) begin
      frame_r <= res_code_w[irpd_pkg::FRAME_W-1:0];
      wheel_r <= wheel;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_code  = frame_r;
  assign out_recognized  = wheel_r.recognized;
  assign out_left_speed  = wheel_r.left_speed;
  assign out_right_speed = wheel_r.right_speed;

  // a waiting result is never dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r)
    else $error("pending result lost");

  // input is held back only while an item sits in the input register and a result waits
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r && out_valid_r)
    else $error("spurious input stall");

  // unmapped commands carry zero speeds
  a_unrec_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !wheel_r.recognized |->
      (wheel_r.left_speed == '0) && (wheel_r.right_speed == '0))
    else $error("speed on unrecognized code");

endmodule

`default_nettype wire
